// ===== sv/lgpg_pkg.sv =====
package lgpg_pkg;

  // field widths
  localparam int CFG_W       = 24;
  localparam int ADV_W       = 16;
  localparam int OUT_PHASE_W = 16;
  localparam int OUT_LEGS    = 4;
  localparam int IDX_W       = 3;

  // dividend of the gait clock reduction: time plus advance
  localparam int DVD_W = CFG_W + 1;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PERIOD  = 3'd0;
  localparam logic [IDX_W-1:0] REG_STANCE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET0 = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET2 = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET3 = 3'd5;

  // gait modes
  localparam logic [1:0] MODE_WAVE   = 2'd0;
  localparam logic [1:0] MODE_SWING  = 2'd1;
  localparam logic [1:0] MODE_STANCE = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] PERIOD_RST  = 24'd400000;
  localparam logic [CFG_W-1:0] STANCE_RST  = 24'd200000;
  localparam logic [CFG_W-1:0] OFFSET0_RST = 24'd0;
  localparam logic [CFG_W-1:0] OFFSET1_RST = 24'd200000;
  localparam logic [CFG_W-1:0] OFFSET2_RST = 24'd200000;
  localparam logic [CFG_W-1:0] OFFSET3_RST = 24'd0;

  localparam logic [CFG_W-1:0] PERIOD_MIN = 24'd2;
  localparam logic [CFG_W-1:0] STANCE_MIN = 24'd1;

endpackage

// ===== sv/legged_gait_phase_generator_core.sv =====
// One request is worked on at a time.
// The gait clock is reduced modulo the period by a bit-serial remainder unit,
// then each leg takes one quotient bit per cycle on a shared divider.
// Reset (synchronous, active high) restores default registers, zeroes the gait
// time, contacts and pending switches, and sets held phases to half and the
// previous mode to swing.
module legged_gait_phase_generator_core #(
  parameter int LEG_COUNT  = 4,
  parameter int PHASE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [lgpg_pkg::IDX_W-1:0]          cfg_index,
  input  logic [lgpg_pkg::CFG_W-1:0]          cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          mode,
  input  logic [lgpg_pkg::ADV_W-1:0]          advance_us,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lgpg_pkg::OUT_PHASE_W-1:0]    leg0_phase,
  output logic [lgpg_pkg::OUT_PHASE_W-1:0]    leg1_phase,
  output logic [lgpg_pkg::OUT_PHASE_W-1:0]    leg2_phase,
  output logic [lgpg_pkg::OUT_PHASE_W-1:0]    leg3_phase,
  output logic [lgpg_pkg::OUT_LEGS-1:0]       contact_mask
);

  localparam int LW    = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
  localparam int W     = lgpg_pkg::CFG_W;
  localparam int DW    = lgpg_pkg::DVD_W;
  localparam int CNT_W = $clog2((PHASE_BITS > DW) ? PHASE_BITS : DW);
  localparam int OPW   = lgpg_pkg::OUT_PHASE_W;
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [LW-1:0]    LEG_LAST  = LW'(LEG_COUNT - 1);
  localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(DW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PHASE_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_SETUP, S_OFF, S_TIME, S_PREP, S_DIV, S_LEG, S_DONE
  } state_t;

  // configuration registers
  logic [W-1:0] cfg_period;
  logic [W-1:0] cfg_stance;
  logic [W-1:0] cfg_off [4];

  // gait state
  logic [W-1:0]            gait_time;
  logic [1:0]              prev_mode;
  logic [LEG_COUNT-1:0]    held_contact;
  logic [PHASE_BITS-1:0]   held_phase [LEG_COUNT];
  logic [LEG_COUNT-1:0]    pending;

  // working registers
  state_t                  state;
  logic [1:0]              mode_r;
  logic [W-1:0]            p_r;
  logic [W-1:0]            s_r;
  logic [DW-1:0]           dvd;
  logic [W-1:0]            rem;
  logic [W-1:0]            den;
  logic [PHASE_BITS-1:0]   quo;
  logic [CNT_W-1:0]        cnt;
  logic                    chg;
  logic                    pend_on;
  logic [LW-1:0]           leg;
  logic [W-1:0]            off_r;
  logic [W-1:0]            t_r;
  logic                    ct_w;
  logic [PHASE_BITS-1:0]   work_ph [LEG_COUNT];
  logic [LEG_COUNT-1:0]    work_ct;

  // combinational helpers
  logic [W-1:0]            p_clamp;
  logic [W-1:0]            s_low;
  logic [W-1:0]            s_clamp;
  logic [1:0]              mode_in;
  logic [DW-1:0]           rem_sh;
  logic [DW-1:0]           rem_sub;
  logic [DW-1:0]           div_sh;
  logic [DW-1:0]           div_sub;
  logic [2:0]              leg_x;
  logic [W-1:0]            off_sel;
  logic [DW-1:0]           t_wrap;
  logic [PHASE_BITS:0]     cur_eval;
  logic [PHASE_BITS:0]     prev_eval;
  logic                    h_ct;
  logic [PHASE_BITS-1:0]   h_ph;
  logic                    o_ct;
  logic [PHASE_BITS-1:0]   o_ph;
  logic [OPW-1:0]          phase_fin [lgpg_pkg::OUT_LEGS];
  logic [lgpg_pkg::OUT_LEGS-1:0] ct_fin;

  // contact and phase of one leg under a given mode
  function automatic logic [PHASE_BITS:0] eval_leg(input logic [1:0] m, input logic wct,
                                                   input logic [PHASE_BITS-1:0] wph);
    logic [PHASE_BITS:0] r;
    unique case (m)
      lgpg_pkg::MODE_SWING:  r = {1'b0, PHASE_HALF};
      lgpg_pkg::MODE_STANCE: r = {1'b1, PHASE_HALF};
      default:               r = {wct, wph};
    endcase
    return r;
  endfunction

  // period and stance clamping
  always_comb begin
    p_clamp = (cfg_period < lgpg_pkg::PERIOD_MIN) ? lgpg_pkg::PERIOD_MIN : cfg_period;
    s_low   = (cfg_stance < lgpg_pkg::STANCE_MIN) ? lgpg_pkg::STANCE_MIN : cfg_stance;
    s_clamp = (s_low > p_clamp - W'(1)) ? p_clamp - W'(1) : s_low;
    mode_in = (mode == lgpg_pkg::MODE_SWING || mode == lgpg_pkg::MODE_STANCE) ?
              mode : lgpg_pkg::MODE_WAVE;
  end

  // bit-serial remainder and quotient steps
  always_comb begin
    rem_sh  = {rem, dvd[DW-1]};
    rem_sub = rem_sh - {1'b0, p_r};
    div_sh  = {rem, 1'b0};
    div_sub = div_sh - {1'b0, den};
  end

  // leg offset selection and offset time
  always_comb begin
    leg_x   = 3'(leg);
    off_sel = leg_x[2] ? '0 : cfg_off[leg_x[1:0]];
    t_wrap  = {1'b0, gait_time} + {1'b0, p_r} - {1'b0, off_r};
  end

  // per-leg mode resolution and switch hold
  always_comb begin
    cur_eval  = eval_leg(mode_r, ct_w, quo);
    prev_eval = eval_leg(prev_mode, ct_w, quo);
    h_ct = held_contact[leg];
    h_ph = held_phase[leg];
    if (chg) begin
      h_ct = prev_eval[PHASE_BITS];
      h_ph = prev_eval[PHASE_BITS-1:0];
      if (mode_r == lgpg_pkg::MODE_STANCE && prev_mode == lgpg_pkg::MODE_SWING) begin
        h_ct = 1'b1;
      end else if (mode_r == lgpg_pkg::MODE_SWING && prev_mode == lgpg_pkg::MODE_STANCE) begin
        h_ct = 1'b0;
      end
    end
    o_ct = cur_eval[PHASE_BITS];
    o_ph = cur_eval[PHASE_BITS-1:0];
    if (pend_on && (o_ct != h_ct)) begin
      o_ct = h_ct;
      o_ph = h_ph;
    end
  end

  // visible legs, phase cut to the port width
  for (genvar k = 0; k < lgpg_pkg::OUT_LEGS; k++) begin : g_fin
    if (k < LEG_COUNT) begin : g_leg
      logic [PHASE_BITS+OPW-1:0] ext;
      assign ext          = {{OPW{1'b0}}, work_ph[k]};
      assign phase_fin[k] = ext[OPW-1:0];
      assign ct_fin[k]    = work_ct[k];
    end else begin : g_none
      assign phase_fin[k] = '0;
      assign ct_fin[k]    = 1'b0;
    end
  end

  assign in_ready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_period <= lgpg_pkg::PERIOD_RST;
      cfg_stance <= lgpg_pkg::STANCE_RST;
      cfg_off[0] <= lgpg_pkg::OFFSET0_RST;
      cfg_off[1] <= lgpg_pkg::OFFSET1_RST;
      cfg_off[2] <= lgpg_pkg::OFFSET2_RST;
      cfg_off[3] <= lgpg_pkg::OFFSET3_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lgpg_pkg::REG_PERIOD:  cfg_period <= cfg_data;
        lgpg_pkg::REG_STANCE:  cfg_stance <= cfg_data;
        lgpg_pkg::REG_OFFSET0: cfg_off[0] <= cfg_data;
        lgpg_pkg::REG_OFFSET1: cfg_off[1] <= cfg_data;
        lgpg_pkg::REG_OFFSET2: cfg_off[2] <= cfg_data;
        lgpg_pkg::REG_OFFSET3: cfg_off[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, gait state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      gait_time    <= '0;
      prev_mode    <= lgpg_pkg::MODE_SWING;
      held_contact <= '0;
      pending      <= '0;
      for (int i = 0; i < LEG_COUNT; i++) begin
        held_phase[i] <= PHASE_HALF;
      end
      out_valid    <= 1'b0;
    end else begin
      // result taken; the hand-over state refills the slot itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        // take a request and latch the clamped configuration
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= mode_in;
            p_r    <= p_clamp;
            s_r    <= s_clamp;
            dvd    <= {1'b0, gait_time} + DW'(advance_us);
            rem    <= '0;
            cnt    <= '0;
            state  <= S_MOD;
          end
        end
        // gait clock modulo period, one dividend bit per cycle
        S_MOD: begin
          if (rem_sh >= {1'b0, p_r}) begin
            rem <= rem_sub[W-1:0];
          end else begin
            rem <= rem_sh[W-1:0];
          end
          dvd <= {dvd[DW-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
          if (cnt == MOD_LAST) begin
            state <= S_SETUP;
          end
        end
        // store gait time and open a switch if the mode changed
        S_SETUP: begin
          gait_time <= rem;
          chg       <= (mode_r != prev_mode);
          pend_on   <= (mode_r != prev_mode) || (|pending);
          if ((mode_r != prev_mode) && !(|pending)) begin
            pending <= '1;
          end
          leg   <= '0;
          state <= S_OFF;
        end
        // offset clamped to the period
        S_OFF: begin
          off_r <= (off_sel > p_r) ? p_r : off_sel;
          state <= S_TIME;
        end
        // offset time within the period
        S_TIME: begin
          if (gait_time >= off_r) begin
            t_r <= gait_time - off_r;
          end else begin
            t_r <= t_wrap[W-1:0];
          end
          state <= S_PREP;
        end
        // pick stance or swing fraction
        S_PREP: begin
          ct_w <= (t_r < s_r);
          if (t_r < s_r) begin
            rem <= t_r;
            den <= s_r;
          end else begin
            rem <= t_r - s_r;
            den <= p_r - s_r;
          end
          quo   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (div_sh >= {1'b0, den}) begin
            rem <= div_sub[W-1:0];
            quo <= {quo[PHASE_BITS-2:0], 1'b1};
          end else begin
            rem <= div_sh[W-1:0];
            quo <= {quo[PHASE_BITS-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == DIV_LAST) begin
            state <= S_LEG;
          end
        end
        // resolve the leg against held values
        S_LEG: begin
          held_contact[leg] <= h_ct;
          held_phase[leg]   <= h_ph;
          if (pend_on && (cur_eval[PHASE_BITS] == h_ct)) begin
            pending[leg] <= 1'b0;
          end
          work_ct[leg] <= o_ct;
          work_ph[leg] <= o_ph;
          if (leg == LEG_LAST) begin
            state <= S_DONE;
          end else begin
            leg   <= leg + LW'(1);
            state <= S_OFF;
          end
        end
        // hand over the result once the output slot is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            leg0_phase   <= phase_fin[0];
            leg1_phase   <= phase_fin[1];
            leg2_phase   <= phase_fin[2];
            leg3_phase   <= phase_fin[3];
            contact_mask <= ct_fin;
            out_valid    <= 1'b1;
            if (pend_on && !(|pending)) begin
              prev_mode <= mode_r;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
